>>> hw/rtl/sstr_pkg.sv
// shared constants, types and codes for the step sequencer trigger ramp block
// no dependencies; used by step_sequencer_trigger_ramp_core
package sstr_pkg;

  // sequencer geometry and time base
  localparam int unsigned StepCount = 16;
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned PosWidth  = $clog2(StepCount);
  localparam int unsigned DistWidth = $clog2(StepCount + 1);

  // ramp format: unsigned Q0.16 with one extra bit so that one is representable
  localparam int unsigned RampFrac  = 16;
  localparam int unsigned RampWidth = RampFrac + 1;
  localparam int unsigned CntWidth  = $clog2(RampFrac);

  // item field widths
  localparam int unsigned ModeWidth = 2;
  localparam int unsigned IdxWidth  = 4;

  // stream packing
  localparam int unsigned InFields  = IdxWidth + TimeWidth;
  localparam int unsigned InDataW   = ((InFields + 7) / 8) * 8;
  localparam int unsigned OutFields = 1 + PosWidth + RampWidth + DistWidth + StepCount;
  localparam int unsigned OutDataW  = ((OutFields + 7) / 8) * 8;

  // operation codes carried in tuser
  typedef enum logic [ModeWidth-1:0] {
    MODE_ADVANCE = 2'd0,
    MODE_TOGGLE  = 2'd1,
    MODE_RESET   = 2'd2,
    MODE_SAMPLE  = 2'd3
  } mode_e;

  typedef logic [TimeWidth-1:0] time_t;
  typedef logic [StepCount-1:0] pattern_t;

  // one result item
  typedef struct packed {
    pattern_t               pattern_bits;
    logic [DistWidth-1:0]   steps_to_next;
    logic [RampWidth-1:0]   ramp;
    logic [PosWidth-1:0]    step_position;
    logic                   trigger;
  } result_t;

endpackage

>>> hw/rtl/step_sequencer_trigger_ramp_core.sv
// step sequencer trigger ramp: 16-step circular trigger sequencer with ramp output
// depends on sstr_pkg; single module, datapath under a small fsm
//
// Usage:
//   Input items arrive on the s_axis group: tuser carries the mode (advance,
//   toggle, reset to step 0, sample), tdata the step index and a timestamp.
//   Every accepted item yields exactly one result item on the m_axis group with
//   the trigger flag, step position, ramp, distance to next step and pattern.
//   The enable register is written through cfg_we_i/cfg_wdata_i; the user must
//   write it only while idle, as the block itself does not enforce this.
//   A result passes through ST_SETUP, ST_DIVIDE if the ramp is divided, and
//   ST_FINISH; an advance onto a set step first goes through ST_SEARCH, ST_SPAN.
//   The ramp quotient takes one restoring-divide step per cycle (16 steps),
//   and the search for the next set step checks one step per cycle.
//   The block takes one item at a time and is ready again the cycle after the
//   result is loaded, so it never takes a new item before the last is done.
//   A finished result sits in an output register; the next item is accepted
//   while it waits. If the receiver stalls, the block holds its next result
//   internally until the output register frees up.
//   Reset clears the pattern, position, enable and all time state but now_q.
module step_sequencer_trigger_ramp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: enable
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: step_index[3:0], timestamp[35:4], zero fill
  input  logic [sstr_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [sstr_pkg::ModeWidth-1:0] s_axis_tuser,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: trigger[0], step_position[4:1], ramp[21:5], steps_to_next[26:22],
  //        pattern_bits[42:27], zero fill
  output logic [sstr_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned TW  = sstr_pkg::TimeWidth;
  localparam int unsigned PW  = sstr_pkg::PosWidth;
  localparam int unsigned DW  = sstr_pkg::DistWidth;
  localparam int unsigned SC  = sstr_pkg::StepCount;
  localparam int unsigned RF  = sstr_pkg::RampFrac;
  localparam int unsigned RW  = sstr_pkg::RampWidth;
  localparam int unsigned CW  = sstr_pkg::CntWidth;
  localparam int unsigned PRW = TW + DW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SPAN,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e                 state_q, state_d;
  sstr_pkg::pattern_t     pattern_q, pattern_d;
  logic [PW-1:0]          pos_q, pos_d;
  sstr_pkg::time_t        last_q, last_d;
  sstr_pkg::time_t        period_q, period_d;
  sstr_pkg::time_t        trig_time_q, trig_time_d;
  sstr_pkg::time_t        span_q, span_d;
  logic [DW-1:0]          dist_q, dist_d;
  logic                   enable_q, enable_d;
  sstr_pkg::time_t        now_q, now_d;
  logic                   trig_q, trig_d;
  logic [PW-1:0]          k_q, k_d;
  sstr_pkg::time_t        rem_q, rem_d;
  logic [RW-1:0]          quo_q, quo_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  sstr_pkg::result_t      out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  // input unpacking
  sstr_pkg::mode_e        in_mode;
  logic [sstr_pkg::IdxWidth-1:0] in_idx;
  sstr_pkg::time_t        in_time;

  // datapath helpers
  logic [PW-1:0]          pos_inc;
  logic [PW:0]            probe_sum;
  logic [PW-1:0]          probe_idx;
  logic [PRW-1:0]         product;
  sstr_pkg::time_t        elapsed;
  logic [TW:0]            rem_shift;
  logic [TW:0]            rem_diff;
  logic                   out_free;

  assign in_mode = sstr_pkg::mode_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[sstr_pkg::IdxWidth-1:0];
  assign in_time = s_axis_tdata[sstr_pkg::IdxWidth +: TW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(sstr_pkg::OutDataW - sstr_pkg::OutFields){1'b0}}, out_q};
  assign out_free      = !out_valid_q || m_axis_tready;

  // next position with wrap
  assign pos_inc = (pos_q == PW'(SC - 1)) ? '0 : pos_q + 1'b1;

  // circular probe of the step k ahead of the current position
  assign probe_sum = {1'b0, pos_q} + {1'b0, k_q};
  assign probe_idx = (probe_sum >= (PW+1)'(SC)) ? PW'(probe_sum - (PW+1)'(SC))
                                                : probe_sum[PW-1:0];

  // span multiply: period times (distance + 1), narrow second operand
  assign product = PRW'(period_q) * PRW'(dist_q + 1'b1);

  // subtract/compare logic for elapsed time and divide steps
  assign elapsed   = now_q - trig_time_q;
  assign rem_shift = {rem_q, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, span_q};

  // next-state and datapath control
  always_comb begin
    state_d     = state_q;
    pattern_d   = pattern_q;
    pos_d       = pos_q;
    last_d      = last_q;
    period_d    = period_q;
    trig_time_d = trig_time_q;
    span_d      = span_q;
    dist_d      = dist_q;
    enable_d    = cfg_we_i ? cfg_wdata_i : enable_q;
    now_d       = now_q;
    trig_d      = trig_q;
    k_d         = k_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          now_d   = in_time;
          trig_d  = 1'b0;
          state_d = ST_SETUP;
          unique case (in_mode)
            sstr_pkg::MODE_ADVANCE: begin
              pos_d    = pos_inc;
              period_d = in_time - last_q;
              last_d   = in_time;
              if (pattern_q[pos_inc]) begin
                trig_time_d = in_time;
                trig_d      = enable_q;
                k_d         = PW'(1);
                state_d     = ST_SEARCH;
              end
            end
            sstr_pkg::MODE_TOGGLE: begin
              if (enable_q && ({1'b0, in_idx} < ($bits(in_idx)+1)'(SC))) begin
                pattern_d[PW'(in_idx)] = !pattern_q[PW'(in_idx)];
              end
            end
            sstr_pkg::MODE_RESET: begin
              pos_d = '0;
            end
            sstr_pkg::MODE_SAMPLE: begin
            end
            default: begin
            end
          endcase
        end
      end

      // one step of the pattern checked per cycle
      ST_SEARCH: begin
        if (pattern_q[probe_idx]) begin
          dist_d  = DW'(k_q);
          state_d = ST_SPAN;
        end else if (k_q == PW'(SC - 1)) begin
          dist_d  = DW'(SC);
          state_d = ST_SPAN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      // saturate the span to the time width
      ST_SPAN: begin
        if (product[PRW-1:TW] != '0) begin
          span_d = '1;
        end else begin
          span_d = product[TW-1:0];
        end
        state_d = ST_SETUP;
      end

      // zero span or elapsed past span saturates the ramp
      ST_SETUP: begin
        if ((span_q == '0) || (elapsed >= span_q)) begin
          quo_d   = RW'(1) << RF;
          state_d = ST_FINISH;
        end else begin
          rem_d   = elapsed;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIVIDE;
        end
      end

      // restoring divide, one quotient bit per cycle
      ST_DIVIDE: begin
        if (!rem_diff[TW]) begin
          rem_d = rem_diff[TW-1:0];
          quo_d = {quo_q[RW-2:0], 1'b1};
        end else begin
          rem_d = rem_shift[TW-1:0];
          quo_d = {quo_q[RW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(RF - 1)) begin
          state_d = ST_FINISH;
        end
      end

      // hand the result to the output register once it is free
      ST_FINISH: begin
        if (out_free) begin
          out_d.trigger       = trig_q;
          out_d.step_position = pos_q;
          out_d.ramp          = quo_q;
          out_d.steps_to_next = dist_q;
          out_d.pattern_bits  = pattern_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pattern_q   <= '0;
      pos_q       <= '0;
      last_q      <= '0;
      period_q    <= '0;
      trig_time_q <= '0;
      span_q      <= '0;
      dist_q      <= '0;
      enable_q    <= 1'b0;
      trig_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pattern_q   <= pattern_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      period_q    <= period_d;
      trig_time_q <= trig_time_d;
      span_q      <= span_d;
      dist_q      <= dist_d;
      enable_q    <= enable_d;
      trig_q      <= trig_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    k_q   <= k_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

endmodule
